// ----- hdl/ggs_pkg.sv -----
// Shared constants, types and tables for the go-to-goal steering block.
package ggs_pkg;

  localparam int ANGLE_ITERATIONS = 16;

  localparam int POS_W     = 16;
  localparam int ANG_OUT_W = 17;
  localparam int GAIN_W    = 8;
  localparam int RAD_W     = 16;
  localparam int R2_W      = 2 * RAD_W;
  localparam int CFG_W     = 16;
  localparam int CFG_IW    = 2;

  localparam int DIFF_W     = POS_W + 1;
  localparam int SQ_W       = 2 * POS_W;
  localparam int SQRT_STEPS = DIFF_W;
  localparam int S_W        = 2 * SQRT_STEPS;
  localparam int ROOT_W     = SQRT_STEPS;
  localparam int REM_W      = ROOT_W + 3;

  localparam int CORDIC_PRE = 8;
  localparam int CW         = DIFF_W + CORDIC_PRE + 3;
  localparam int ZW         = 20;

  localparam int NUM_CELLS = (ANGLE_ITERATIONS > SQRT_STEPS) ? ANGLE_ITERATIONS : SQRT_STEPS;
  localparam int CELL_IW   = $clog2(NUM_CELLS);

  localparam int ATAN_N  = 32;
  localparam int ATAN_IW = 5;

  localparam logic signed [ZW-1:0] PI_Q16 = 20'sd205887;
  localparam int PI_Q13     = 25736;
  localparam int TWO_PI_Q13 = 51472;

  localparam logic [CFG_IW-1:0] REG_HEADING_GAIN  = 2'd0;
  localparam logic [CFG_IW-1:0] REG_DISTANCE_GAIN = 2'd1;
  localparam logic [CFG_IW-1:0] REG_ARRIVE_RADIUS = 2'd2;

  localparam logic [GAIN_W-1:0] HEADING_GAIN_RST  = 8'd112;
  localparam logic [GAIN_W-1:0] DISTANCE_GAIN_RST = 8'd16;
  localparam logic [RAD_W-1:0]  ARRIVE_RADIUS_RST = 16'd512;

  // round(atan(2^-i) * 65536)
  localparam logic signed [ZW-1:0] ATAN_TAB [ATAN_N] = '{
    20'sd51472, 20'sd30386, 20'sd16055, 20'sd8150, 20'sd4091, 20'sd2047, 20'sd1024, 20'sd512,
    20'sd256,   20'sd128,   20'sd64,    20'sd32,   20'sd16,   20'sd8,    20'sd4,    20'sd2,
    20'sd1,     20'sd0,     20'sd0,     20'sd0,    20'sd0,    20'sd0,    20'sd0,    20'sd0,
    20'sd0,     20'sd0,     20'sd0,     20'sd0,    20'sd0,    20'sd0,    20'sd0,    20'sd0
  };

  typedef logic signed [POS_W-1:0]     pos_t;
  typedef logic signed [ANG_OUT_W-1:0] ang_out_t;

  typedef struct packed {
    logic                    arrived;
    logic signed [POS_W-1:0] heading;
    logic signed [CW-1:0]    x;
    logic signed [CW-1:0]    y;
    logic signed [ZW-1:0]    z;
    logic [S_W-1:0]          srest;
    logic [REM_W-1:0]        rem;
    logic [ROOT_W-1:0]       root;
  } cell_t;

endpackage

// ----- hdl/ggs_in_if.sv -----
// Pose request channel: robot pose and goal point.
interface ggs_in_if;
  logic          valid;
  logic          ready;
  ggs_pkg::pos_t robot_x;
  ggs_pkg::pos_t robot_y;
  ggs_pkg::pos_t robot_heading;
  ggs_pkg::pos_t goal_x;
  ggs_pkg::pos_t goal_y;

  modport source (output valid, output robot_x, output robot_y, output robot_heading,
                  output goal_x, output goal_y, input ready);
  modport sink (input valid, input robot_x, input robot_y, input robot_heading,
                input goal_x, input goal_y, output ready);
endinterface

// ----- hdl/ggs_out_if.sv -----
// Command channel: speed commands and arrival flag.
interface ggs_out_if;
  logic              valid;
  logic              ready;
  logic [15:0]       linear_speed;
  ggs_pkg::ang_out_t angular_speed;
  logic              arrived;

  modport source (output valid, output linear_speed, output angular_speed, output arrived,
                  input ready);
  modport sink (input valid, input linear_speed, input angular_speed, input arrived,
                output ready);
endinterface

// ----- hdl/ggs_front.sv -----
// Front stages: offsets, squares, squared distance, arrival test, CORDIC pre-rotation.
module ggs_front (
  input  logic                        clk,
  input  logic                        rst,
  ggs_in_if.sink                      pose,
  input  logic [ggs_pkg::R2_W-1:0]    r2,
  output logic                        dn_valid,
  input  logic                        dn_ready,
  output ggs_pkg::cell_t              dn_data
);
  import ggs_pkg::*;

  logic                     f1_valid;
  logic                     f2_valid;
  logic                     f1_ready;
  logic                     f2_ready;
  logic                     f3_ready;
  logic signed [DIFF_W-1:0] f1_dx;
  logic signed [DIFF_W-1:0] f1_dy;
  pos_t                     f1_hd;
  logic [SQ_W-1:0]          f2_sqx;
  logic [SQ_W-1:0]          f2_sqy;
  logic signed [CW-1:0]     f2_x;
  logic signed [CW-1:0]     f2_y;
  logic signed [ZW-1:0]     f2_z;
  pos_t                     f2_hd;
  logic signed [2*DIFF_W-1:0] prod_x;
  logic signed [2*DIFF_W-1:0] prod_y;
  logic signed [CW-1:0]     x_scaled;
  logic signed [CW-1:0]     y_scaled;
  logic [S_W-1:0]           s_sum;

  assign f3_ready   = !dn_valid || dn_ready;
  assign f2_ready   = !f2_valid || f3_ready;
  assign f1_ready   = !f1_valid || f2_ready;
  assign pose.ready = f1_ready;

  assign prod_x   = f1_dx * f1_dx;
  assign prod_y   = f1_dy * f1_dy;
  assign x_scaled = CW'(f1_dx) <<< CORDIC_PRE;
  assign y_scaled = CW'(f1_dy) <<< CORDIC_PRE;
  assign s_sum    = S_W'(f2_sqx) + S_W'(f2_sqy);

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid <= 1'b0;
      f2_valid <= 1'b0;
      dn_valid <= 1'b0;
    end else begin
      if (f1_ready) begin
        f1_valid <= pose.valid;
      end
      if (f2_ready) begin
        f2_valid <= f1_valid;
      end
      if (f3_ready) begin
        dn_valid <= f2_valid;
      end
    end

    if (pose.valid && f1_ready) begin
      f1_dx <= DIFF_W'(pose.goal_x) - DIFF_W'(pose.robot_x);
      f1_dy <= DIFF_W'(pose.goal_y) - DIFF_W'(pose.robot_y);
      f1_hd <= pose.robot_heading;
    end

    if (f1_valid && f2_ready) begin
      f2_sqx <= prod_x[SQ_W-1:0];
      f2_sqy <= prod_y[SQ_W-1:0];
      f2_hd  <= f1_hd;
      // left half plane: rotate by pi first
      if (f1_dx[DIFF_W-1]) begin
        f2_x <= -x_scaled;
        f2_y <= -y_scaled;
        f2_z <= f1_dy[DIFF_W-1] ? -PI_Q16 : PI_Q16;
      end else begin
        f2_x <= x_scaled;
        f2_y <= y_scaled;
        f2_z <= '0;
      end
    end

    if (f2_valid && f3_ready) begin
      dn_data.arrived <= (s_sum <= S_W'(r2));
      dn_data.heading <= f2_hd;
      dn_data.x       <= f2_x;
      dn_data.y       <= f2_y;
      dn_data.z       <= f2_z;
      dn_data.srest   <= s_sum;
      dn_data.rem     <= '0;
      dn_data.root    <= '0;
    end
  end

endmodule

// ----- hdl/ggs_cell.sv -----
// Chain cell: vectoring CORDIC step and/or square-root digit, per idx.
module ggs_cell (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [ggs_pkg::CELL_IW-1:0]  idx,
  input  logic                         up_valid,
  output logic                         up_ready,
  input  ggs_pkg::cell_t               up_data,
  output logic                         dn_valid,
  input  logic                         dn_ready,
  output ggs_pkg::cell_t               dn_data
);
  import ggs_pkg::*;

  logic                 do_rot;
  logic                 do_root;
  logic                 rot_up;
  logic signed [CW-1:0] xs;
  logic signed [CW-1:0] ys;
  logic [REM_W-1:0]     rem2;
  logic [REM_W-1:0]     trial;
  cell_t                nxt;

  assign do_rot  = int'(idx) < ANGLE_ITERATIONS;
  assign do_root = int'(idx) < SQRT_STEPS;
  assign rot_up  = !up_data.y[CW-1];
  assign xs      = up_data.x >>> idx;
  assign ys      = up_data.y >>> idx;
  assign rem2    = {up_data.rem[REM_W-3:0], up_data.srest[S_W-1 -: 2]};
  assign trial   = REM_W'({up_data.root, 2'b01});

  always_comb begin
    nxt = up_data;
    if (do_rot) begin
      if (rot_up) begin
        nxt.x = up_data.x + ys;
        nxt.y = up_data.y - xs;
        nxt.z = up_data.z + ATAN_TAB[ATAN_IW'(idx)];
      end else begin
        nxt.x = up_data.x - ys;
        nxt.y = up_data.y + xs;
        nxt.z = up_data.z - ATAN_TAB[ATAN_IW'(idx)];
      end
    end
    if (do_root) begin
      nxt.srest = {up_data.srest[S_W-3:0], 2'b00};
      if (rem2 >= trial) begin
        nxt.rem  = rem2 - trial;
        nxt.root = {up_data.root[ROOT_W-2:0], 1'b1};
      end else begin
        nxt.rem  = rem2;
        nxt.root = {up_data.root[ROOT_W-2:0], 1'b0};
      end
    end
  end

  assign up_ready = !dn_valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
    if (up_valid && up_ready) begin
      dn_data <= nxt;
    end
  end

  a_cell_hold: assert property (@(posedge clk) disable iff (rst)
    dn_valid && !dn_ready |=> dn_valid && $stable(dn_data))
    else $error("cell dropped or changed a stalled request");

endmodule

// ----- hdl/ggs_back.sv -----
// Back stages: bearing, wrapped heading error, gains, rounding, saturation, output register.
module ggs_back (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [ggs_pkg::GAIN_W-1:0]   heading_gain,
  input  logic [ggs_pkg::GAIN_W-1:0]   distance_gain,
  input  logic                         up_valid,
  output logic                         up_ready,
  input  ggs_pkg::cell_t               up_data,
  ggs_out_if.source                    cmd
);
  import ggs_pkg::*;

  localparam int ERR_W      = ANG_OUT_W + 1;
  localparam int LIN_PROD_W = ROOT_W + GAIN_W;
  localparam int LIN_RND_W  = LIN_PROD_W + 1 - 4;
  localparam int ANG_PROD_W = POS_W + GAIN_W + 1;
  localparam int ANG_SUM_W  = ANG_PROD_W + 1;

  localparam logic signed [ERR_W-1:0] E_PI     = ERR_W'(PI_Q13);
  localparam logic signed [ERR_W-1:0] E_TWO_PI = ERR_W'(TWO_PI_Q13);
  localparam logic signed [ANG_SUM_W-1:0] ANG_MAX = ANG_SUM_W'((1 << (ANG_OUT_W - 1)) - 1);
  localparam logic signed [ANG_SUM_W-1:0] ANG_MIN = -ANG_MAX - ANG_SUM_W'(1);

  logic                        b1_valid;
  logic                        b2_valid;
  logic                        b2_ready;
  logic                        b3_ready;
  logic signed [ZW-1:0]        z_rnd;
  ang_out_t                    bearing;
  logic signed [ERR_W-1:0]     err0;
  logic signed [ERR_W-1:0]     err1;
  logic signed [ERR_W-1:0]     err2;
  pos_t                        b1_err;
  logic [LIN_PROD_W-1:0]       b1_lin_prod;
  logic                        b1_arrived;
  logic signed [ANG_PROD_W-1:0] ang_prod;
  logic [LIN_RND_W-1:0]        lin_rnd;
  logic [15:0]                 lin_sat;
  logic signed [ANG_PROD_W-1:0] b2_ang_prod;
  logic [15:0]                 b2_lin;
  logic                        b2_arrived;
  logic signed [ANG_SUM_W-1:0] ang_rnd;
  logic signed [ANG_SUM_W-1:0] ang_sat;

  assign b3_ready = !cmd.valid || cmd.ready;
  assign b2_ready = !b2_valid || b3_ready;
  assign up_ready = !b1_valid || b2_ready;

  assign z_rnd   = (up_data.z + ZW'(4)) >>> 3;
  assign bearing = ANG_OUT_W'(z_rnd);
  assign err0    = ERR_W'(bearing) - ERR_W'(up_data.heading);
  assign err1    = (err0 > E_PI) ? err0 - E_TWO_PI :
                   (err0 <= -E_PI) ? err0 + E_TWO_PI : err0;
  assign err2    = (err1 > E_PI) ? err1 - E_TWO_PI :
                   (err1 <= -E_PI) ? err1 + E_TWO_PI : err1;

  assign ang_prod = b1_err * $signed({1'b0, heading_gain});
  assign lin_rnd  = LIN_RND_W'((({1'b0, b1_lin_prod}) + (LIN_PROD_W + 1)'(8)) >> 4);
  assign lin_sat  = (|lin_rnd[LIN_RND_W-1:16]) ? 16'hFFFF : lin_rnd[15:0];

  assign ang_rnd = (ANG_SUM_W'(b2_ang_prod) + ANG_SUM_W'(256)) >>> 9;
  assign ang_sat = (ang_rnd > ANG_MAX) ? ANG_MAX :
                   (ang_rnd < ANG_MIN) ? ANG_MIN : ang_rnd;

  always_ff @(posedge clk) begin
    if (rst) begin
      b1_valid  <= 1'b0;
      b2_valid  <= 1'b0;
      cmd.valid <= 1'b0;
    end else begin
      if (up_ready) begin
        b1_valid <= up_valid;
      end
      if (b2_ready) begin
        b2_valid <= b1_valid;
      end
      if (b3_ready) begin
        cmd.valid <= b2_valid;
      end
    end

    if (up_valid && up_ready) begin
      b1_err      <= POS_W'(err2);
      b1_lin_prod <= up_data.root * distance_gain;
      b1_arrived  <= up_data.arrived;
    end

    if (b1_valid && b2_ready) begin
      b2_ang_prod <= ang_prod;
      b2_lin      <= lin_sat;
      b2_arrived  <= b1_arrived;
    end

    if (b2_valid && b3_ready) begin
      cmd.arrived       <= b2_arrived;
      cmd.linear_speed  <= b2_arrived ? '0 : b2_lin;
      cmd.angular_speed <= b2_arrived ? '0 : ANG_OUT_W'(ang_sat);
    end
  end

  a_err_wrapped: assert property (@(posedge clk) disable iff (rst)
    up_valid |-> (err2 > -E_PI) && (err2 <= E_PI))
    else $error("heading error outside the half-open pi interval");

  a_arrived_zero: assert property (@(posedge clk) disable iff (rst)
    cmd.valid && cmd.arrived |-> (cmd.linear_speed == '0) && (cmd.angular_speed == '0))
    else $error("arrived request carries nonzero speed");

endmodule

// ----- hdl/go_to_goal_steering.sv -----
// Top level of the go-to-goal proportional steering controller.
// Takes one pose request per clock while the output is not stalled, and returns one speed
// command per request, in order. The pipeline has three front stages, the cell chain,
// whose length is the larger of the CORDIC iteration count and the 17 square-root digits,
// and three back stages including the output register. Every stage holds its request
// under backpressure, so a stalled output fills the chain before pose.ready drops. Gains
// and arrival radius apply to each request when it reaches the stage that reads them.
module go_to_goal_steering (
  input  logic                        clk,
  input  logic                        rst,
  ggs_in_if.sink                      pose,
  ggs_out_if.source                   cmd,
  input  logic                        cfg_we,
  input  logic [ggs_pkg::CFG_IW-1:0]  cfg_index,
  input  logic [ggs_pkg::CFG_W-1:0]   cfg_data
);
  import ggs_pkg::*;

  localparam logic [R2_W-1:0] R2_RST = R2_W'(ARRIVE_RADIUS_RST) * R2_W'(ARRIVE_RADIUS_RST);

  logic [GAIN_W-1:0]   heading_gain;
  logic [GAIN_W-1:0]   distance_gain;
  logic [RAD_W-1:0]    arrive_radius;
  logic [R2_W-1:0]     r2;
  logic [NUM_CELLS:0]  chain_valid;
  logic [NUM_CELLS:0]  chain_ready;
  cell_t               chain_data [NUM_CELLS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      heading_gain  <= HEADING_GAIN_RST;
      distance_gain <= DISTANCE_GAIN_RST;
      arrive_radius <= ARRIVE_RADIUS_RST;
      r2            <= R2_RST;
    end else begin
      r2 <= R2_W'(arrive_radius) * R2_W'(arrive_radius);
      if (cfg_we) begin
        unique case (cfg_index)
          REG_HEADING_GAIN:  heading_gain  <= cfg_data[GAIN_W-1:0];
          REG_DISTANCE_GAIN: distance_gain <= cfg_data[GAIN_W-1:0];
          REG_ARRIVE_RADIUS: arrive_radius <= cfg_data[RAD_W-1:0];
          default: ;
        endcase
      end
    end
  end

  ggs_front u_front (
    .clk      (clk),
    .rst      (rst),
    .pose     (pose),
    .r2       (r2),
    .dn_valid (chain_valid[0]),
    .dn_ready (chain_ready[0]),
    .dn_data  (chain_data[0])
  );

  for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
    ggs_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .idx      (CELL_IW'(k)),
      .up_valid (chain_valid[k]),
      .up_ready (chain_ready[k]),
      .up_data  (chain_data[k]),
      .dn_valid (chain_valid[k+1]),
      .dn_ready (chain_ready[k+1]),
      .dn_data  (chain_data[k+1])
    );
  end

  ggs_back u_back (
    .clk           (clk),
    .rst           (rst),
    .heading_gain  (heading_gain),
    .distance_gain (distance_gain),
    .up_valid      (chain_valid[NUM_CELLS]),
    .up_ready      (chain_ready[NUM_CELLS]),
    .up_data       (chain_data[NUM_CELLS]),
    .cmd           (cmd)
  );

  a_r2_track: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> r2 == R2_W'($past(arrive_radius)) * R2_W'($past(arrive_radius)))
    else $error("squared arrival radius out of step with register");

endmodule

// ----- verif/testbench.sv -----
// Self-checking testbench for go_to_goal_steering: predicts each speed command from its pose request.
module testbench;
  import ggs_pkg::*;

  localparam int PIPE_LAT    = NUM_CELLS + 6;
  localparam int CYCLE_LIMIT = 400000;

  localparam logic [CFG_IW-1:0] REG_NONE = 2'd3;

  localparam logic [GAIN_W-1:0] HDG_GAIN_INIT  = 8'd112;
  localparam logic [GAIN_W-1:0] DIST_GAIN_INIT = 8'd16;
  localparam logic [RAD_W-1:0]  RADIUS_INIT    = 16'd512;

  localparam longint HALF_TURN = 25736;
  localparam longint FULL_TURN = 51472;
  localparam longint PI_ACC    = 205887;

  typedef struct {
    logic [15:0]         lin;
    logic signed [16:0]  ang;
    logic                arr;
  } steer_cmd_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_IW-1:0] cfg_index;
  logic [CFG_W-1:0]  cfg_data;

  ggs_in_if  pose ();
  ggs_out_if cmd ();

  logic [GAIN_W-1:0] hdg_gain   = HDG_GAIN_INIT;
  logic [GAIN_W-1:0] dist_gain  = DIST_GAIN_INIT;
  logic [RAD_W-1:0]  arr_radius = RADIUS_INIT;

  steer_cmd_t pending_cmds[$];
  int err_count   = 0;
  int stall_left  = 0;
  int cycle_count = 0;
  bit quiet       = 1'b0;

  go_to_goal_steering u_top (
    .clk       (clk),
    .rst       (rst),
    .pose      (pose),
    .cmd       (cmd),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint atan_q16(input int i);
    case (i)
      0: return 51472;
      1: return 30386;
      2: return 16055;
      3: return 8150;
      4: return 4091;
      5: return 2047;
      6: return 1024;
      7: return 512;
      8: return 256;
      9: return 128;
      10: return 64;
      11: return 32;
      12: return 16;
      13: return 8;
      14: return 4;
      15: return 2;
      16: return 1;
      default: return 0;
    endcase
  endfunction

  function automatic steer_cmd_t steer_predict(input pos_t rx, ry, hd, gx, gy);
    steer_cmd_t c;
    longint dx, dy, x, y, z, xs, ys, err, ang;
    longint unsigned s, r2, rem, root, bitv, lin;
    int i;
    dx = longint'(gx) - longint'(rx);
    dy = longint'(gy) - longint'(ry);
    s = dx * dx + dy * dy;
    r2 = longint'(arr_radius) * longint'(arr_radius);
    c.lin = '0;
    c.ang = '0;
    c.arr = 1'b1;
    if (s <= r2) return c;
    c.arr = 1'b0;

    rem = s;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > rem) bitv >>= 2;
    while (bitv != 0) begin
      if (rem >= root + bitv) begin
        rem -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    lin = (root * dist_gain + 8) >> 4;
    c.lin = (lin > 65535) ? 16'hFFFF : lin[15:0];

    // vectoring rotation, left half plane folded over by pi
    x = dx * 256;
    y = dy * 256;
    z = 0;
    if (x < 0) begin
      z = (y >= 0) ? PI_ACC : -PI_ACC;
      x = -x;
      y = -y;
    end
    for (i = 0; i < ANGLE_ITERATIONS && i < 32; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x += ys;
        y -= xs;
        z += atan_q16(i);
      end else begin
        x -= ys;
        y += xs;
        z -= atan_q16(i);
      end
    end

    err = ((z + 4) >>> 3) - longint'(hd);
    while (err > HALF_TURN) err -= FULL_TURN;
    while (err <= -HALF_TURN) err += FULL_TURN;
    ang = (err * longint'(hdg_gain) + 256) >>> 9;
    if (ang > 65535) ang = 65535;
    if (ang < -65536) ang = -65536;
    c.ang = ang[16:0];
    return c;
  endfunction

  always @(posedge clk) begin : cmd_monitor
    steer_cmd_t want;
    if (rst) begin
      cmd.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (cmd.valid && cmd.ready) begin
        if (pending_cmds.size() == 0) begin
          $error("speed command with no request pending");
          err_count++;
        end else begin
          want = pending_cmds.pop_front();
          if (cmd.linear_speed !== want.lin) begin
            $error("linear_speed: expected %0d, got %0d", want.lin, cmd.linear_speed);
            err_count++;
          end
          if (cmd.angular_speed !== want.ang) begin
            $error("angular_speed: expected %0d, got %0d", want.ang, cmd.angular_speed);
            err_count++;
          end
          if (cmd.arrived !== want.arr) begin
            $error("arrived: expected %0d, got %0d", want.arr, cmd.arrived);
            err_count++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        cmd.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 12) - 1;
        cmd.ready <= 1'b0;
      end else begin
        cmd.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic send_pose(input pos_t rx, ry, hd, gx, gy);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      pose.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    pose.valid         <= 1'b1;
    pose.robot_x       <= rx;
    pose.robot_y       <= ry;
    pose.robot_heading <= hd;
    pose.goal_x        <= gx;
    pose.goal_y        <= gy;
    @(posedge clk);
    while (!pose.ready) @(posedge clk);
    pending_cmds.insert(pending_cmds.size(), steer_predict(rx, ry, hd, gx, gy));
  endtask

  task automatic send_random_pose();
    pos_t rx, ry, hd, gx, gy;
    int span, pmode;
    rx = pos_t'($urandom);
    ry = pos_t'($urandom);
    gx = pos_t'($urandom);
    gy = pos_t'($urandom);
    if ($urandom_range(0, 9) == 0) hd = pos_t'($urandom);
    else hd = pos_t'(int'($urandom_range(0, 51472)) - 25736);
    pmode = $urandom_range(0, 19);
    if (pmode >= 11 && pmode < 16) begin
      // goal close to the robot, around the arrival radius
      span = int'(arr_radius) + 256;
      if (span > 16000) span = 16000;
      gx = pos_t'(int'(rx) + int'($urandom_range(0, 2 * span)) - span);
      gy = pos_t'(int'(ry) + int'($urandom_range(0, 2 * span)) - span);
    end else if (pmode >= 16) begin
      if ($urandom_range(0, 1)) gx = rx;
      else gy = ry;
    end
    send_pose(rx, ry, hd, gx, gy);
  endtask

  task automatic wait_idle();
    pose.valid <= 1'b0;
    while (pending_cmds.size() != 0) @(posedge clk);
    repeat (PIPE_LAT + 4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      REG_HEADING_GAIN:  hdg_gain = data[GAIN_W-1:0];
      REG_DISTANCE_GAIN: dist_gain = data[GAIN_W-1:0];
      REG_ARRIVE_RADIUS: arr_radius = data[RAD_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [7:0] hg, input logic [7:0] dg, input logic [15:0] rad);
    wait_idle();
    write_reg(REG_HEADING_GAIN, {8'h00, hg});
    write_reg(REG_DISTANCE_GAIN, {8'h00, dg});
    write_reg(REG_ARRIVE_RADIUS, rad);
    cfg_we <= 1'b0;
  endtask

  task automatic test_directed_cases();
    send_pose(16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
    send_pose(-16'sd32768, -16'sd32768, 16'sd25736, 16'sd32767, 16'sd32767);
    send_pose(16'sd32767, 16'sd32767, -16'sd25736, -16'sd32768, -16'sd32768);
    send_pose(16'sd32767, -16'sd32768, 16'sd0, -16'sd32768, 16'sd32767);
    send_pose(-16'sd32768, 16'sd32767, 16'sd0, 16'sd32767, -16'sd32768);
    // on and just past the arrival circle
    send_pose(16'sd100, 16'sd50, 16'sd0, 16'sd612, 16'sd50);
    send_pose(16'sd100, 16'sd50, 16'sd0, 16'sd613, 16'sd50);
    send_pose(16'sd0, 16'sd0, 16'sd0, 16'sd0, -16'sd512);
    send_pose(16'sd0, 16'sd0, 16'sd0, 16'sd362, 16'sd362);
    send_pose(16'sd0, 16'sd0, 16'sd0, 16'sd363, 16'sd363);
    // straight behind: bearing pi against heading -pi
    send_pose(16'sd1000, 16'sd0, -16'sd25736, -16'sd1000, 16'sd0);
    send_pose(16'sd0, 16'sd0, 16'sd25736, -16'sd3000, -16'sd1);
    send_pose(16'sd0, 16'sd0, 16'sd12868, 16'sd0, 16'sd5000);
    send_pose(16'sd0, 16'sd0, -16'sd12868, 16'sd0, -16'sd5000);
    send_pose(16'sd0, 16'sd0, 16'sd0, 16'sd7000, 16'sd0);
    // heading beyond +-pi
    send_pose(16'sd0, 16'sd0, 16'sd32767, -16'sd4000, 16'sd2000);
    send_pose(16'sd0, 16'sd0, -16'sd32768, 16'sd4000, -16'sd2000);
    send_pose(16'sd0, 16'sd0, 16'sd25736, 16'sd3000, -16'sd3000);
    send_pose(16'sd0, 16'sd0, -16'sd25736, -16'sd3000, 16'sd3000);
  endtask

  task automatic test_register_writes();
    wait_idle();
    write_reg(REG_NONE, 16'hFFFF);
    write_reg(REG_HEADING_GAIN, 16'hA5FF);
    write_reg(REG_DISTANCE_GAIN, 16'h5AFF);
    write_reg(REG_ARRIVE_RADIUS, 16'hFFFF);
    cfg_we <= 1'b0;
    send_pose(16'sd5, 16'sd5, 16'sd0, 16'sd5, 16'sd5);
    send_pose(-16'sd32768, -16'sd32768, 16'sd0, 16'sd32767, 16'sd32767);
    send_pose(16'sd32767, -16'sd32768, 16'sd20000, -16'sd32768, 16'sd32767);
    send_pose(-16'sd32768, 16'sd0, -16'sd20000, 16'sd32767, 16'sd0);
    repeat (4) send_random_pose();

    set_config(8'd0, 8'd0, 16'd0);
    send_pose(16'sd9, -16'sd9, 16'sd0, 16'sd9, -16'sd9);
    send_pose(16'sd0, 16'sd0, 16'sd0, 16'sd1, 16'sd0);
    send_pose(-16'sd32768, -16'sd32768, 16'sd0, 16'sd32767, 16'sd32767);
    repeat (4) send_random_pose();

    set_config(8'd255, 8'd255, 16'd1);
    send_pose(16'sd0, 16'sd0, 16'sd0, 16'sd1, 16'sd0);
    send_pose(16'sd0, 16'sd0, 16'sd0, 16'sd1, 16'sd1);
    send_pose(16'sd0, 16'sd0, 16'sd25736, -16'sd1, -16'sd1);
    repeat (4) send_random_pose();
  endtask

  task automatic test_random_sweep();
    int phase;
    for (phase = 0; phase < 6; phase++) begin
      case (phase)
        0: set_config(HDG_GAIN_INIT, DIST_GAIN_INIT, RADIUS_INIT);
        1: set_config(8'd255, 8'd255, 16'd0);
        2: set_config(8'd0, 8'd0, 16'd65535);
        3: set_config(8'd1, 8'd1, 16'd1);
        default: set_config(GAIN_W'($urandom_range(0, 255)), GAIN_W'($urandom_range(0, 255)),
                            RAD_W'($urandom_range(0, 1) ? $urandom_range(0, 4095)
                                                        : $urandom_range(0, 65535)));
      endcase
      repeat (165) send_random_pose();
    end
  endtask

  task automatic test_quiet_stream();
    set_config(8'd200, 8'd100, 16'd3000);
    quiet = 1'b1;
    repeat (60) send_random_pose();
  endtask

  initial begin
    rst                <= 1'b1;
    cfg_we             <= 1'b0;
    cfg_index          <= '0;
    cfg_data           <= '0;
    pose.valid         <= 1'b0;
    pose.robot_x       <= '0;
    pose.robot_y       <= '0;
    pose.robot_heading <= '0;
    pose.goal_x        <= '0;
    pose.goal_y        <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    test_directed_cases();
    test_register_writes();
    test_random_sweep();
    test_quiet_stream();
    wait_idle();

    if (err_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
